// ----- rtl/core/ps2_mouse_packet_decoder_unit_defines.svh -----
// -----------------------------------------------------------------------------
// PS/2 mouse packet decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// -----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_DECODER_UNIT_DEFINES_SVH
`define PS2_MOUSE_PACKET_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, idle while rst is high
`define PS2MD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, idle while rst is high
`define PS2MD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ps2md_pkg.sv -----
// -----------------------------------------------------------------------------
// PS/2 mouse packet decoder package
// Widths, codes, result type and saturating helpers shared by the decoder.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ps2md_pkg;

  localparam int ACCUM_WIDTH = 16;
  localparam int DELTA_W     = 10;
  localparam int OUT_W       = 16;

  localparam int IN_TDATA_W  = 8;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [1:0] KIND_RESEND  = 2'd0;
  localparam logic [1:0] KIND_BUTTONS = 2'd1;
  localparam logic [1:0] KIND_MOTION  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_X      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_Y      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_TIMEOUT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_PERIOD = 3'd4;

  localparam logic [15:0] BYTE_TIMEOUT_RESET  = 16'd500;
  localparam logic [7:0]  REPORT_PERIOD_RESET = 8'd10;

  typedef logic signed [ACCUM_WIDTH-1:0] acc_t;
  typedef logic signed [DELTA_W-1:0]     delta_t;
  typedef logic signed [OUT_W-1:0]       out16_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] buttons;
    out16_t     motion_x;
    out16_t     motion_y;
    out16_t     wheel;
  } result_t;

  function automatic acc_t sat_add(acc_t a, delta_t d);
    logic signed [ACCUM_WIDTH:0] s;
    acc_t                        r;
    s = (ACCUM_WIDTH+1)'(a) + (ACCUM_WIDTH+1)'(d);
    if (s[ACCUM_WIDTH] != s[ACCUM_WIDTH-1]) begin
      r = s[ACCUM_WIDTH] ? {1'b1, {(ACCUM_WIDTH-1){1'b0}}}
                         : {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
    end else begin
      r = s[ACCUM_WIDTH-1:0];
    end
    return r;
  endfunction

  function automatic out16_t to_out16(acc_t v);
    logic signed [32:0] w;
    out16_t             r;
    w = 33'(v);
    if (w > 33'sd32767) begin
      r = 16'sh7FFF;
    end else if (w < -33'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = w[15:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/ps2_mouse_packet_decoder_unit.sv -----
// Takes one beat per clock while s_tready is high: a mouse byte (tuser 0) or a
// millisecond tick (tuser 1). Each beat is decoded in the cycle it is accepted
// and any result goes to the result register, or to the skid register while
// m_tready is low. A two-deep output stage (result register plus skid
// register) lets s_tready stay high while one result waits; s_tready drops only
// when both are full. Configuration writes should be made with the block idle.
// -----------------------------------------------------------------------------
// PS/2 mouse packet decoder
// Frames 3- or 4-byte mouse packets, accumulates motion with saturation,
// reports button changes at once and motion on a tick period.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ps2md_pkg::IN_TDATA_W-1:0]    s_tdata,   // [7:0] data_byte
  input  logic [ps2md_pkg::IN_TUSER_W-1:0]    s_tuser,   // [0] op
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] button_left, [1] button_right, [2] button_middle, [18:3] motion_x,
  // [34:19] motion_y, [50:35] wheel, [55:51] zero
  output logic [ps2md_pkg::OUT_TDATA_W-1:0]   m_tdata,
  output logic [ps2md_pkg::OUT_TUSER_W-1:0]   m_tuser,   // [1:0] kind
  input  logic                                cfg_we,
  input  logic [ps2md_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ps2md_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ps2md_pkg::*;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  logic        scroll_mode;
  logic        invert_x;
  logic        invert_y;
  logic [15:0] byte_timeout_ticks;
  logic [7:0]  report_period_ticks;

  logic [1:0]  pos, pos_next;
  logic [7:0]  pkt [3];
  logic [2:0]  buttons, buttons_next;
  acc_t        sum_x, sum_x_next;
  acc_t        sum_y, sum_y_next;
  acc_t        sum_w, sum_w_next;
  logic        armed, armed_next;
  logic [15:0] tcount, tcount_next;
  logic [7:0]  pcount, pcount_next;

  logic        accept;
  logic [7:0]  b;
  logic        we0, we1, we2;
  logic        finish;
  logic [7:0]  fin_y;
  logic [3:0]  fin_w;
  delta_t      dx, dy, dw, mx, my;
  acc_t        add_x, add_y, add_w;
  logic [15:0] tinc;
  logic [7:0]  pinc;

  logic        res_valid;
  result_t     res;
  logic        out_valid, skid_valid;
  result_t     out_q, skid_q;

  assign accept   = s_tvalid & s_tready;
  assign s_tready = ~skid_valid;
  assign b        = s_tdata[7:0];

  // movement deltas
  assign mx    = {pkt[0][4], pkt[0][4], pkt[1]};
  assign my    = {pkt[0][5], pkt[0][5], fin_y};
  assign dx    = invert_x ? -mx : mx;
  assign dy    = invert_y ? my : -my;
  assign dw    = {{(DELTA_W-4){fin_w[3]}}, fin_w};
  assign add_x = sat_add(sum_x, dx);
  assign add_y = sat_add(sum_y, dy);
  assign add_w = sat_add(sum_w, dw);
  assign tinc  = tcount + 16'd1;
  assign pinc  = pcount + 8'd1;

  always_comb begin
    pos_next     = pos;
    buttons_next = buttons;
    sum_x_next   = sum_x;
    sum_y_next   = sum_y;
    sum_w_next   = sum_w;
    armed_next   = armed;
    tcount_next  = tcount;
    pcount_next  = pcount;
    we0          = 1'b0;
    we1          = 1'b0;
    we2          = 1'b0;
    finish       = 1'b0;
    fin_y        = b;
    fin_w        = 4'd0;
    res_valid    = 1'b0;
    res.kind     = KIND_RESEND;
    res.motion_x = '0;
    res.motion_y = '0;
    res.wheel    = '0;
    if (pos == POS_FOURTH) begin
      fin_y = pkt[2];
      fin_w = b[3:0];
    end
    if (accept) begin
      if (s_tuser[0] == OP_BYTE) begin
        armed_next  = 1'b0;
        tcount_next = '0;
        case (pos)
          POS_FIRST: begin
            if (!b[3]) begin
              res_valid = 1'b1;
              res.kind  = KIND_RESEND;
            end else begin
              we0        = 1'b1;
              pos_next   = POS_SECOND;
              armed_next = 1'b1;
            end
          end
          POS_SECOND: begin
            we1        = 1'b1;
            pos_next   = POS_THIRD;
            armed_next = 1'b1;
          end
          POS_THIRD: begin
            if (!scroll_mode) begin
              finish = 1'b1;
            end else begin
              we2        = 1'b1;
              pos_next   = POS_FOURTH;
              armed_next = 1'b1;
            end
          end
          default: begin
            finish = 1'b1;
          end
        endcase
        if (finish) begin
          pos_next   = POS_FIRST;
          sum_x_next = add_x;
          sum_y_next = add_y;
          sum_w_next = add_w;
          if (pkt[0][2:0] != buttons) begin
            buttons_next = pkt[0][2:0];
            res_valid    = 1'b1;
            res.kind     = KIND_BUTTONS;
          end
        end
      end else begin
        if (armed) begin
          if (tinc >= byte_timeout_ticks) begin
            pos_next    = POS_FIRST;
            armed_next  = 1'b0;
            tcount_next = '0;
          end else begin
            tcount_next = tinc;
          end
        end
        if (pinc >= report_period_ticks) begin
          pcount_next = '0;
          if (sum_x != '0 || sum_y != '0 || sum_w != '0) begin
            res_valid    = 1'b1;
            res.kind     = KIND_MOTION;
            res.motion_x = to_out16(sum_x);
            res.motion_y = to_out16(sum_y);
            res.wheel    = to_out16(sum_w);
            sum_x_next   = '0;
            sum_y_next   = '0;
            sum_w_next   = '0;
          end
        end else begin
          pcount_next = pinc;
        end
      end
    end
    res.buttons = buttons_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_mode         <= 1'b0;
      invert_x            <= 1'b0;
      invert_y            <= 1'b0;
      byte_timeout_ticks  <= BYTE_TIMEOUT_RESET;
      report_period_ticks <= REPORT_PERIOD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SCROLL_MODE:   scroll_mode         <= cfg_data[0];
        CFG_INVERT_X:      invert_x            <= cfg_data[0];
        CFG_INVERT_Y:      invert_y            <= cfg_data[0];
        CFG_BYTE_TIMEOUT:  byte_timeout_ticks  <= cfg_data[15:0];
        CFG_REPORT_PERIOD: report_period_ticks <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= POS_FIRST;
      buttons <= '0;
      sum_x   <= '0;
      sum_y   <= '0;
      sum_w   <= '0;
      armed   <= 1'b0;
      tcount  <= '0;
      pcount  <= '0;
    end else begin
      pos     <= pos_next;
      buttons <= buttons_next;
      sum_x   <= sum_x_next;
      sum_y   <= sum_y_next;
      sum_w   <= sum_w_next;
      armed   <= armed_next;
      tcount  <= tcount_next;
      pcount  <= pcount_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we0) pkt[0] <= b;
    if (we1) pkt[1] <= b;
    if (we2) pkt[2] <= b;
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_tready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tready || !out_valid) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_q.kind;
  assign m_tdata  = {5'd0, out_q.wheel, out_q.motion_y, out_q.motion_x,
                     out_q.buttons[2], out_q.buttons[1], out_q.buttons[0]};

endmodule

// ----- rtl/core/ps2md_checker.sv -----
// -----------------------------------------------------------------------------
// PS/2 mouse packet decoder checker
// Port-level assertions on the result stream, bound to the top level.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ps2_mouse_packet_decoder_unit_defines.svh"

module ps2md_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [ps2md_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [ps2md_pkg::OUT_TUSER_W-1:0] m_tuser
);
  import ps2md_pkg::*;

  `PS2MD_ASSERT_NOW(a_no_motion_outside_report, m_tvalid && m_tuser != KIND_MOTION, m_tdata[50:3] == '0, "motion fields set outside a motion report")
  `PS2MD_ASSERT_NOW(a_motion_report_nonzero, m_tvalid && m_tuser == KIND_MOTION, m_tdata[50:3] != '0, "motion report with all sums zero")
  `PS2MD_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[55:51] == '0, "tdata padding not zero")
  `PS2MD_ASSERT_NEXT(a_hold_stalled, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")

endmodule

bind ps2_mouse_packet_decoder_unit ps2md_checker u_checker (.*);
